/* rtl/sbf_pkg.sv */
// ----------------------------------------------------------------------------
// sbf_pkg: shared types, widths and constants of the sine beep generator
// field widths, fixed-point formats and the quarter-wave sine entry function
// ----------------------------------------------------------------------------
package sbf_pkg;

  // default module parameters
  localparam int unsigned DEF_SAMPLE_RATE     = 44100;
  localparam int unsigned DEF_SINE_TABLE_BITS = 10;
  localparam int unsigned DEF_PHASE_BITS      = 32;

  // beat field widths
  localparam int unsigned OP_W     = 1;
  localparam int unsigned FREQ_W   = 15;
  localparam int unsigned DUR_W    = 14;
  localparam int unsigned SAMPLE_W = 15;

  // internal state widths and formats
  localparam int unsigned N_W       = 22;  // sample count and index
  localparam int unsigned ENV_FRAC  = 24;  // envelope is q24
  localparam int unsigned ENV_W     = ENV_FRAC + 1;
  localparam int unsigned RECIP_W   = 28;  // holds 10 * 2^24 / n
  localparam int unsigned SINE_W    = 15;  // table entries, q15 magnitude
  localparam int unsigned SINE_FRAC = 15;
  localparam int unsigned AMP_SHIFT = 14;  // amplitude 16383 = 2^14 - 1
  localparam int unsigned MS_PER_S  = 1000;
  localparam int unsigned RAMP_NUM  = 10 * (1 << ENV_FRAC);

  typedef enum logic [OP_W-1:0] {
    OP_TICK  = 1'b0,
    OP_START = 1'b1
  } op_e;

  // quarter-wave sine magnitude for k in 0..2^q_bits, q15 with rounding
  function automatic logic [SINE_W-1:0] quarter_sine(input int unsigned k,
                                                     input int unsigned q_bits);
    longint unsigned one_q28;
    longint unsigned x;
    longint unsigned x2;
    longint unsigned t;
    longint unsigned s;
    longint unsigned r;
    one_q28 = 64'd1 << 28;
    x  = (64'd421657429 * longint'(k)) >> q_bits;
    x2 = (x * x) >> 28;
    t  = one_q28;
    t  = one_q28 - (((x2 * t) >> 28) / 64'd110);
    t  = one_q28 - (((x2 * t) >> 28) / 64'd72);
    t  = one_q28 - (((x2 * t) >> 28) / 64'd42);
    t  = one_q28 - (((x2 * t) >> 28) / 64'd20);
    t  = one_q28 - (((x2 * t) >> 28) / 64'd6);
    s  = (x * t) >> 28;
    r  = (s * 64'd32767 + (64'd1 << 27)) >> 28;
    return r[SINE_W-1:0];
  endfunction

endpackage

/* rtl/sbf_in_if.sv */
// ----------------------------------------------------------------------------
// sbf_in_if: command channel of the sine beep generator
// valid/ready channel carrying an op code, a tone frequency and a duration
// ----------------------------------------------------------------------------
interface sbf_in_if import sbf_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   op;
  logic [FREQ_W-1:0] tone_freq;
  logic [DUR_W-1:0]  duration_ms;

  modport source (output valid, op, tone_freq, duration_ms, input ready);
  modport sink   (input valid, op, tone_freq, duration_ms, output ready);
endinterface

/* rtl/sbf_out_if.sv */
// ----------------------------------------------------------------------------
// sbf_out_if: sample channel of the sine beep generator
// valid/ready channel carrying one signed sample and an end-of-tone flag
// ----------------------------------------------------------------------------
interface sbf_out_if import sbf_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample;
  logic                       last;

  modport source (output valid, sample, last, input ready);
  modport sink   (input valid, sample, last, output ready);
endinterface

/* rtl/sbf_div.sv */
// ----------------------------------------------------------------------------
// sbf_div: bit-serial restoring divider
// shifts one dividend bit per cycle, msb first, for a given number of steps
// ----------------------------------------------------------------------------
module sbf_div #(
  parameter int unsigned DVD_W = 47,
  parameter int unsigned DVS_W = 22,
  parameter int unsigned QUO_W = 32,
  parameter int unsigned CNT_W = 6
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [DVD_W-1:0] dividend_i,  // left aligned
  input  logic [DVS_W-1:0] divisor_i,
  input  logic [CNT_W-1:0] steps_i,
  output logic             done_o,
  output logic [QUO_W-1:0] quotient_o
);

  logic [DVD_W-1:0] dvd_q;
  logic [DVS_W-1:0] dvs_q;
  logic [DVS_W-1:0] rem_q;
  logic [QUO_W-1:0] quo_q;
  logic [CNT_W-1:0] cnt_q;
  logic             done_q;

  logic [DVS_W:0]   rem_sh;
  logic             qbit;
  logic [DVS_W:0]   rem_d;

  always_comb begin
    rem_sh = {rem_q, dvd_q[DVD_W-1]};
    qbit   = (rem_sh >= {1'b0, dvs_q});
    rem_d  = qbit ? (rem_sh - {1'b0, dvs_q}) : rem_sh;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else if (start_i) begin
      cnt_q  <= steps_i;
      done_q <= 1'b0;
    end else if (cnt_q != '0) begin
      cnt_q  <= cnt_q - 1'b1;
      done_q <= (cnt_q == CNT_W'(1));
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dividend_i;
      dvs_q <= divisor_i;
      rem_q <= '0;
      quo_q <= '0;
    end else if (cnt_q != '0) begin
      dvd_q <= dvd_q << 1;
      rem_q <= rem_d[DVS_W-1:0];
      quo_q <= {quo_q[QUO_W-2:0], qbit};
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

/* rtl/sine_beep_with_linear_fade_core.sv */
// ----------------------------------------------------------------------------
// sine_beep_with_linear_fade_core: dds sine tone with a linear fade envelope
// start beats set up a tone, tick beats return one enveloped sine sample each
// ----------------------------------------------------------------------------
//
//   channel  dir  beat payload                         notes
//   in_i     in   op, tone_freq, duration_ms           op start or tick
//   out_o    out  sample (signed), last                one beat per live tick
//
// a start beat runs three serial divisions through one shared divider, or
//   two for a zero-length tone, which skips the ramp reciprocal
// a tick beat runs a prep step, N_W/2 envelope digits, 8 product digits and
//   a final scale step; the envelope and product loops shift-add 2-bit digits
// ticks while idle are taken and produce nothing
// the output register holds a finished sample while the next beat is taken
// reset clears the tone state, so the block comes up idle
//
module sine_beep_with_linear_fade_core import sbf_pkg::*; #(
  parameter int unsigned SAMPLE_RATE     = DEF_SAMPLE_RATE,
  parameter int unsigned SINE_TABLE_BITS = DEF_SINE_TABLE_BITS,
  parameter int unsigned PHASE_BITS      = DEF_PHASE_BITS
) (
  input  logic clk_i,
  input  logic rst_ni,
  sbf_in_if.sink    in_i,
  sbf_out_if.source out_o
);

  // --------------------------------------------------------------------------
  // derived sizes
  // --------------------------------------------------------------------------
  localparam int unsigned RATE_W    = $clog2(SAMPLE_RATE + 1);
  localparam int unsigned PROD_W    = RATE_W + DUR_W;          // rate * ms
  localparam int unsigned STEP_S    = FREQ_W + PHASE_BITS;     // freq << phase
  localparam int unsigned RAMP_S    = RECIP_W;                 // 10 << 24
  localparam int unsigned DVD_A     = (STEP_S > PROD_W) ? STEP_S : PROD_W;
  localparam int unsigned DVD_W     = (DVD_A > RAMP_S) ? DVD_A : RAMP_S;
  localparam int unsigned DVS_W     = (RATE_W > N_W) ? RATE_W : N_W;
  localparam int unsigned QUO_W     = (PHASE_BITS > RECIP_W) ? PHASE_BITS : RECIP_W;
  localparam int unsigned DCNT_W    = $clog2(DVD_W + 1);

  localparam int unsigned Q_BITS    = SINE_TABLE_BITS - 2;
  localparam int unsigned ROM_DEPTH = (1 << Q_BITS) + 1;
  localparam int unsigned ADDR_W    = Q_BITS + 1;

  localparam int unsigned ENV_DIG   = (N_W + 1) / 2;
  localparam int unsigned M_SH_W    = 2 * ENV_DIG;
  localparam int unsigned MAG_DIG   = (SINE_W + 1) / 2;
  localparam int unsigned MAG_SH_W  = 2 * MAG_DIG;
  localparam int unsigned CNT_W     = $clog2(ENV_DIG + 1);
  localparam int unsigned I_W       = N_W + 4;                 // holds 10 * i
  localparam int unsigned ES_W      = RECIP_W + 2;             // envelope digit sum
  localparam int unsigned P_W       = SINE_W + ENV_W;          // sine * envelope
  localparam int unsigned S_W       = P_W + AMP_SHIFT;         // times amplitude
  localparam logic [ENV_W-1:0] ENV_ONE = ENV_W'(1) << ENV_FRAC;

  // --------------------------------------------------------------------------
  // sequencer
  // --------------------------------------------------------------------------
  typedef enum logic [7:0] {
    ST_IDLE     = 8'b0000_0001,
    ST_DIV_DUR  = 8'b0000_0010,  // samples = rate * ms / 1000
    ST_DIV_STEP = 8'b0000_0100,  // phase step = freq * 2^phase / rate
    ST_DIV_RAMP = 8'b0000_1000,  // ramp reciprocal = 10 * 2^24 / samples
    ST_PREP     = 8'b0001_0000,  // envelope region, state advance
    ST_ENV      = 8'b0010_0000,  // envelope multiply, 2 bits a cycle
    ST_MUL      = 8'b0100_0000,  // sine times envelope, 2 bits a cycle
    ST_FIN      = 8'b1000_0000   // scale, sign, hand to output register
  } state_e;

  state_e state_q, state_d;

  // tone state
  logic [FREQ_W-1:0]     freq_q,   freq_d;
  logic [PHASE_BITS-1:0] phase_q,  phase_d;
  logic [PHASE_BITS-1:0] step_q,   step_d;
  logic [N_W-1:0]        idx_q,    idx_d;
  logic [N_W-1:0]        total_q,  total_d;
  logic [RECIP_W-1:0]    recip_q,  recip_d;
  logic                  active_q, active_d;

  // per-sample working registers
  logic [SINE_W-1:0]     mag_q;
  logic                  neg_q,     neg_d;
  logic                  last_q,    last_d;
  logic [M_SH_W-1:0]     m_sh_q,    m_sh_d;
  logic [ENV_W-1:0]      env_acc_q, env_acc_d;
  logic                  env_sat_q, env_sat_d;
  logic [MAG_SH_W-1:0]   mag_sh_q,  mag_sh_d;
  logic [P_W-1:0]        prod_q,    prod_d;
  logic [CNT_W-1:0]      cnt_q,     cnt_d;

  // output register
  logic                       out_valid_q;
  logic signed [SAMPLE_W-1:0] out_sample_q;
  logic                       out_last_q;
  logic                       out_load;
  logic [SAMPLE_W-1:0]        sample_val;

  // divider hookup
  logic              div_start;
  logic [DVD_W-1:0]  div_dvd;
  logic [DVS_W-1:0]  div_dvs;
  logic [DCNT_W-1:0] div_steps;
  logic              div_done;
  logic [QUO_W-1:0]  div_quo;

  logic in_fire;
  assign in_fire    = in_i.valid && in_i.ready;
  assign in_i.ready = (state_q == ST_IDLE);

  // --------------------------------------------------------------------------
  // quarter-wave sine table, registered read
  // --------------------------------------------------------------------------
  logic [SINE_W-1:0] sine_rom [ROM_DEPTH];

  for (genvar k = 0; k < ROM_DEPTH; k++) begin : g_rom
    assign sine_rom[k] = quarter_sine(k, Q_BITS);
  end

  logic [SINE_TABLE_BITS-1:0] wave_idx;
  logic [ADDR_W-1:0]          rom_addr;

  always_comb begin
    wave_idx = phase_q[PHASE_BITS-1 -: SINE_TABLE_BITS];
    // odd quadrants run the table backwards
    if (wave_idx[SINE_TABLE_BITS-2])
      rom_addr = (ADDR_W'(1) << Q_BITS) - ADDR_W'(wave_idx[Q_BITS-1:0]);
    else
      rom_addr = ADDR_W'(wave_idx[Q_BITS-1:0]);
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      mag_q <= sine_rom[rom_addr];
    end
  end

  // --------------------------------------------------------------------------
  // shared serial divider
  // --------------------------------------------------------------------------
  sbf_div #(
    .DVD_W (DVD_W),
    .DVS_W (DVS_W),
    .QUO_W (QUO_W),
    .CNT_W (DCNT_W)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dvd),
    .divisor_i  (div_dvs),
    .steps_i    (div_steps),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  // --------------------------------------------------------------------------
  // datapath helpers
  // --------------------------------------------------------------------------
  logic [I_W-1:0]    ten_i;
  logic [I_W-1:0]    nine_n;
  logic              in_rise;
  logic              in_fall;
  logic [N_W-1:0]    fall_cnt;
  logic [1:0]        env_dig;
  logic [ES_W-1:0]   env_sum;
  logic [ENV_W-1:0]  env_val;
  logic [1:0]        mag_dig;
  logic [P_W-1:0]    prod_sum;
  logic [S_W-1:0]    scaled;
  logic [SAMPLE_W-1:0] mag_out;

  always_comb begin
    // envelope region from the current index
    ten_i    = (I_W'(idx_q) << 3) + (I_W'(idx_q) << 1);
    nine_n   = (I_W'(total_q) << 3) + I_W'(total_q);
    in_rise  = (ten_i < I_W'(total_q));
    in_fall  = (ten_i > nine_n);
    fall_cnt = (total_q >= idx_q) ? (total_q - idx_q) : '0;

    // envelope digit step: acc = 4 * acc + d * recip
    env_dig  = m_sh_q[M_SH_W-1 -: 2];
    env_sum  = (ES_W'(env_acc_q) << 2)
             + ({ES_W{env_dig[1]}} & (ES_W'(recip_q) << 1))
             + ({ES_W{env_dig[0]}} & ES_W'(recip_q));

    // product digit step: prod = 4 * prod + d * env
    env_val  = env_sat_q ? ENV_ONE : env_acc_q;
    mag_dig  = mag_sh_q[MAG_SH_W-1 -: 2];
    prod_sum = (prod_q << 2)
             + ({P_W{mag_dig[1]}} & (P_W'(env_val) << 1))
             + ({P_W{mag_dig[0]}} & P_W'(env_val));

    // times 16383 as shift and subtract, then drop the q15 and q24 fractions
    scaled     = (S_W'(prod_q) << AMP_SHIFT) - S_W'(prod_q);
    mag_out    = SAMPLE_W'(scaled >> (SINE_FRAC + ENV_FRAC));
    sample_val = neg_q ? (SAMPLE_W'(0) - mag_out) : mag_out;
  end

  // --------------------------------------------------------------------------
  // next-state logic
  // --------------------------------------------------------------------------
  always_comb begin
    state_d   = state_q;
    freq_d    = freq_q;
    phase_d   = phase_q;
    step_d    = step_q;
    idx_d     = idx_q;
    total_d   = total_q;
    recip_d   = recip_q;
    active_d  = active_q;
    neg_d     = neg_q;
    last_d    = last_q;
    m_sh_d    = m_sh_q;
    env_acc_d = env_acc_q;
    env_sat_d = env_sat_q;
    mag_sh_d  = mag_sh_q;
    prod_d    = prod_q;
    cnt_d     = cnt_q;
    out_load  = 1'b0;
    div_start = 1'b0;
    div_dvd   = '0;
    div_dvs   = '0;
    div_steps = '0;

    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          if (in_i.op == OP_START) begin
            // restart: the running tone, if any, is dropped
            freq_d    = in_i.tone_freq;
            phase_d   = '0;
            idx_d     = '0;
            active_d  = 1'b0;
            div_start = 1'b1;
            div_dvd   = DVD_W'(PROD_W'(SAMPLE_RATE) * PROD_W'(in_i.duration_ms))
                        << (DVD_W - PROD_W);
            div_dvs   = DVS_W'(MS_PER_S);
            div_steps = DCNT_W'(PROD_W);
            state_d   = ST_DIV_DUR;
          end else if (active_q) begin
            state_d = ST_PREP;
          end
        end
      end

      ST_DIV_DUR: begin
        if (div_done) begin
          total_d   = div_quo[N_W-1:0];
          div_start = 1'b1;
          div_dvd   = DVD_W'({freq_q, {PHASE_BITS{1'b0}}}) << (DVD_W - STEP_S);
          div_dvs   = DVS_W'(SAMPLE_RATE);
          div_steps = DCNT_W'(STEP_S);
          state_d   = ST_DIV_STEP;
        end
      end

      ST_DIV_STEP: begin
        if (div_done) begin
          step_d = div_quo[PHASE_BITS-1:0];
          if (total_q != '0) begin
            div_start = 1'b1;
            div_dvd   = DVD_W'(RAMP_NUM) << (DVD_W - RAMP_S);
            div_dvs   = DVS_W'(total_q);
            div_steps = DCNT_W'(RAMP_S);
            state_d   = ST_DIV_RAMP;
          end else begin
            // zero-length tone stays idle
            recip_d = '0;
            state_d = ST_IDLE;
          end
        end
      end

      ST_DIV_RAMP: begin
        if (div_done) begin
          recip_d  = div_quo[RECIP_W-1:0];
          active_d = 1'b1;
          state_d  = ST_IDLE;
        end
      end

      ST_PREP: begin
        neg_d     = phase_q[PHASE_BITS-1];
        last_d    = ((N_W + 1)'(idx_q) + (N_W + 1)'(1)) >= (N_W + 1)'(total_q);
        env_acc_d = '0;
        // hold region is full scale without a multiply
        env_sat_d = !in_rise && !in_fall;
        if (in_rise)
          m_sh_d = M_SH_W'(idx_q);
        else if (in_fall)
          m_sh_d = M_SH_W'(fall_cnt);
        else
          m_sh_d = '0;
        cnt_d    = CNT_W'(ENV_DIG);
        phase_d  = phase_q + step_q;
        idx_d    = idx_q + N_W'(1);
        if (last_d)
          active_d = 1'b0;
        state_d  = ST_ENV;
      end

      ST_ENV: begin
        m_sh_d = m_sh_q << 2;
        // the sum only grows, so passing full scale once is final
        if (env_sum > ES_W'(ENV_ONE))
          env_sat_d = 1'b1;
        else
          env_acc_d = env_sum[ENV_W-1:0];
        cnt_d = cnt_q - CNT_W'(1);
        if (cnt_q == CNT_W'(1)) begin
          mag_sh_d = MAG_SH_W'(mag_q);
          prod_d   = '0;
          cnt_d    = CNT_W'(MAG_DIG);
          state_d  = ST_MUL;
        end
      end

      ST_MUL: begin
        mag_sh_d = mag_sh_q << 2;
        prod_d   = prod_sum;
        cnt_d    = cnt_q - CNT_W'(1);
        if (cnt_q == CNT_W'(1))
          state_d = ST_FIN;
      end

      ST_FIN: begin
        // wait here while the output register still holds an untaken beat
        if (!out_valid_q || out_o.ready) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      phase_q     <= '0;
      step_q      <= '0;
      idx_q       <= '0;
      total_q     <= '0;
      recip_q     <= '0;
      active_q    <= 1'b0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      phase_q  <= phase_d;
      step_q   <= step_d;
      idx_q    <= idx_d;
      total_q  <= total_d;
      recip_q  <= recip_d;
      active_q <= active_d;
      cnt_q    <= cnt_d;
      if (out_load)
        out_valid_q <= 1'b1;
      else if (out_o.ready)
        out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    freq_q    <= freq_d;
    neg_q     <= neg_d;
    last_q    <= last_d;
    m_sh_q    <= m_sh_d;
    env_acc_q <= env_acc_d;
    env_sat_q <= env_sat_d;
    mag_sh_q  <= mag_sh_d;
    prod_q    <= prod_d;
    if (out_load) begin
      out_sample_q <= sample_val;
      out_last_q   <= last_q;
    end
  end

  assign out_o.valid  = out_valid_q;
  assign out_o.sample = out_sample_q;
  assign out_o.last   = out_last_q;

endmodule

/* verif/tb_sine_beep_with_linear_fade_core.sv */
// ----------------------------------------------------------------------------
// tb_sine_beep_with_linear_fade_core: self-checking bench of the sine beep core
// drives start and tick beats, predicts every enveloped sine sample and its
// last flag with a bit-true tone model and compares each sample beat in order
// ----------------------------------------------------------------------------
module tb_sine_beep_with_linear_fade_core;
  import sbf_pkg::*;

  // block configuration, kept at the defaults of the package
  localparam int unsigned SAMPLE_RATE     = DEF_SAMPLE_RATE;
  localparam int unsigned SINE_TABLE_BITS = DEF_SINE_TABLE_BITS;
  localparam int unsigned PHASE_BITS      = DEF_PHASE_BITS;

  // derived constants of the tone model
  localparam int unsigned       QTR       = 1 << (SINE_TABLE_BITS - 2);
  localparam longint unsigned   RATE_L    = SAMPLE_RATE;
  localparam longint unsigned   PH_MASK   = (64'd1 << PHASE_BITS) - 64'd1;
  localparam longint unsigned   CNT_MASK  = (64'd1 << N_W) - 64'd1;
  localparam longint unsigned   ENV_ONE   = 64'd1 << ENV_FRAC;
  localparam longint unsigned   AMPLITUDE = 64'd16383;

  // run control
  localparam int unsigned IDLE_PCT     = 18;      // idle chance per cycle, each side
  localparam int unsigned CALM_FROM    = 10000;   // no idling inside this window
  localparam int unsigned CALM_TO      = 20000;
  localparam int unsigned RANDOM_ITEMS = 1250;
  localparam int unsigned DRAIN_CYCLES = 400;     // beyond the divisions of a last start beat
  localparam int unsigned CYCLE_LIMIT  = 800000;
  localparam int unsigned MAX_PRINTS   = 40;

  typedef struct packed {
    op_e               op;
    logic [FREQ_W-1:0] freq;
    logic [DUR_W-1:0]  dur;
  } cmd_beat_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       last;
  } tone_sample_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  sbf_in_if  in_if ();
  sbf_out_if out_if ();

  sine_beep_with_linear_fade_core #(
    .SAMPLE_RATE     (SAMPLE_RATE),
    .SINE_TABLE_BITS (SINE_TABLE_BITS),
    .PHASE_BITS      (PHASE_BITS)
  ) u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  // pending command beats and samples still owed by the block
  cmd_beat_t    cmd_q [$];
  tone_sample_t tone_q [$];

  // tone model state, two-state so it starts at zero like the block
  longint unsigned qsine [0:QTR];
  bit              tone_on;
  longint unsigned ph_acc;
  longint unsigned ph_step;
  longint unsigned smp_idx;
  longint unsigned smp_total;
  longint unsigned ramp_q24;

  int unsigned cyc;
  int unsigned fail_cnt;
  int unsigned live_items;
  wire         calm = (cyc >= CALM_FROM) && (cyc < CALM_TO);

  always #1 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // mismatch reporting, printing is capped but every miss is counted
  // ---------------------------------------------------------------------------
  task automatic note_mismatch(input string what);
    if (fail_cnt < MAX_PRINTS) $display("MISMATCH cycle %0d: %s", cyc, what);
    fail_cnt++;
  endtask

  // ---------------------------------------------------------------------------
  // quarter-wave entry: pi/2*k/Q in q28, odd taylor series in nested form,
  // then rounded to q15
  // ---------------------------------------------------------------------------
  function automatic longint unsigned sine_entry(input longint unsigned k);
    longint unsigned one;
    longint unsigned x;
    longint unsigned x2;
    longint unsigned t;
    longint unsigned s;
    longint unsigned dv [5];
    one = 64'd1 << 28;
    dv  = '{64'd110, 64'd72, 64'd42, 64'd20, 64'd6};
    x   = (64'd421657429 * k) / QTR;
    x2  = (x * x) >> 28;
    t   = one;
    for (int d = 0; d < 5; d++) t = one - (((x2 * t) >> 28) / dv[d]);
    s = (x * t) >> 28;
    return (s * 64'd32767 + (64'd1 << 27)) >> 28;
  endfunction

  // ---------------------------------------------------------------------------
  // tone model: applies one accepted command beat, queues the sample it owes
  // ---------------------------------------------------------------------------
  task automatic tone_model(input cmd_beat_t b);
    longint unsigned f;
    longint unsigned d;
    longint unsigned idx;
    longint unsigned quad;
    longint unsigned j;
    longint unsigned mag;
    longint unsigned i;
    longint unsigned n;
    longint unsigned env;
    longint unsigned val;
    tone_sample_t    s;
    f = b.freq;
    d = b.dur;
    if (b.op == OP_START) begin
      // a start restarts phase and index even over a running tone
      smp_total = ((RATE_L * d) / MS_PER_S) & CNT_MASK;
      ph_step   = ((f << PHASE_BITS) / RATE_L) & PH_MASK;   // would wrap only at or above the rate
      ph_acc    = 0;
      smp_idx   = 0;
      ramp_q24  = (smp_total != 0) ? (64'd10 * ENV_ONE) / smp_total : 0;
      tone_on   = (smp_total != 0);
    end else if (tone_on) begin
      // sine magnitude from the quadrant and the quarter-wave table
      idx  = (ph_acc & PH_MASK) >> (PHASE_BITS - SINE_TABLE_BITS);
      quad = (idx >> (SINE_TABLE_BITS - 2)) & 64'd3;
      j    = idx & (QTR - 1);
      mag  = quad[0] ? qsine[QTR - j] : qsine[j];
      i    = smp_idx;
      n    = smp_total;
      // linear attack over the first tenth, release over the last tenth
      if (10 * i < n) env = i * ramp_q24;
      else if (10 * i > 9 * n) env = ((n >= i) ? n - i : 0) * ramp_q24;
      else env = ENV_ONE;
      if (env > ENV_ONE) env = ENV_ONE;
      val = (mag * env * AMPLITUDE) >> 39;
      if (quad[1]) val = 64'd0 - val;
      s.sample = val[SAMPLE_W-1:0];
      s.last   = (i + 1 >= n);
      tone_q.push_back(s);
      ph_acc  = (ph_acc + ph_step) & PH_MASK;
      smp_idx = (i + 1) & CNT_MASK;
      if (s.last) tone_on = 1'b0;
    end
    // ticks while idle produce nothing
  endtask

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic void queue_cmd(input op_e op, input int unsigned freq,
                                    input int unsigned dur);
    cmd_beat_t c;
    c.op   = op;
    c.freq = freq[FREQ_W-1:0];
    c.dur  = dur[DUR_W-1:0];
    cmd_q.push_back(c);
  endfunction

  // tick payload fields are ignored by the block, so they carry noise
  function automatic void queue_ticks(input int unsigned cnt);
    for (int unsigned k = 0; k < cnt; k++)
      queue_cmd(OP_TICK, $urandom_range(0, 32767), $urandom_range(0, 16383));
  endfunction

  function automatic int unsigned tone_len(input int unsigned dur);
    return (SAMPLE_RATE * dur) / MS_PER_S;
  endfunction

  // ---------------------------------------------------------------------------
  // command driver: a new beat only after the previous one was taken,
  // random gaps between beats except in the calm window
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : cmd_drive
    cmd_beat_t nxt;
    if (!rst_ni) begin
      in_if.valid       <= 1'b0;
      in_if.op          <= OP_TICK;
      in_if.tone_freq   <= '0;
      in_if.duration_ms <= '0;
    end else begin
      if (!in_if.valid || in_if.ready) begin
        if (cmd_q.size() != 0 && (calm || $urandom_range(0, 99) >= IDLE_PCT)) begin
          nxt = cmd_q.pop_front();
          in_if.valid       <= 1'b1;
          in_if.op          <= nxt.op;
          in_if.tone_freq   <= nxt.freq;
          in_if.duration_ms <= nxt.dur;
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: checks sample beats against the oldest owed sample, then feeds
  // the accepted command beat to the tone model; ready stalls at random
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : sample_watch
    tone_sample_t want;
    cmd_beat_t    got_cmd;
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        if (tone_q.size() == 0) begin
          note_mismatch($sformatf("sample beat %0d last %0b with none owed",
                                  out_if.sample, out_if.last));
        end else begin
          want = tone_q.pop_front();
          if (out_if.sample !== want.sample)
            note_mismatch($sformatf("sample %0d, model %0d", out_if.sample,
                                    want.sample));
          if (out_if.last !== want.last)
            note_mismatch($sformatf("last %0b, model %0b", out_if.last, want.last));
        end
      end
      // prediction after the check, an output never stems from this edge's beat
      if (in_if.valid && in_if.ready) begin
        got_cmd.op   = op_e'(in_if.op);
        got_cmd.freq = in_if.tone_freq;
        got_cmd.dur  = in_if.duration_ms;
        tone_model(got_cmd);
      end
      out_if.ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  // cycle count and watchdog
  always @(posedge clk_i) begin
    cyc <= cyc + 1;
    if (cyc == CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus and end of run
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    int unsigned pick;
    int unsigned dur;
    int unsigned freq;
    int unsigned n;
    int unsigned k;
    rst_ni            = 1'b0;
    live_items        = 0;
    for (int unsigned e = 0; e <= QTR; e++) qsine[e] = sine_entry(e);

    // directed part
    queue_ticks(1);                            // tick while idle
    queue_cmd(OP_START, 440, 0);               // zero duration stays idle
    queue_ticks(1);
    queue_cmd(OP_START, 32767, 16383);         // all-ones fields, step above half rate
    queue_ticks(4);
    queue_cmd(OP_START, 0, 1);                 // restart over a running tone, dc
    queue_ticks(4);
    queue_cmd(OP_START, SAMPLE_RATE / 2, 1);   // exactly half the rate
    queue_ticks(4);
    queue_cmd(OP_START, 11025, 10000);         // quarter rate hits quadrant edges
    queue_ticks(4);

    // random part: mostly whole tones, some cut short, some noise
    while (live_items < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        dur = $urandom_range(1, 3);
        case ($urandom_range(0, 3))
          0:       freq = $urandom_range(0, 32767);
          1:       freq = $urandom_range(0, 200);
          default: freq = $urandom_range(20, 22050);
        endcase
        n = tone_len(dur);
        queue_cmd(OP_START, freq, dur);
        queue_ticks(n + $urandom_range(0, 3)); // trailing ticks find the block idle
        live_items += 1 + n;
      end else if (pick < 88) begin
        dur = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16383);
        k   = $urandom_range(0, 24);
        n   = tone_len(dur);
        queue_cmd(OP_START, $urandom_range(0, 32767), dur);
        queue_ticks(k);
        live_items += 1 + ((k < n) ? k : n);
      end else begin
        repeat ($urandom_range(1, 6)) begin
          if ($urandom_range(0, 1) == 1) begin
            queue_cmd(OP_START, $urandom_range(0, 32767), $urandom_range(0, 16383));
            live_items++;
          end else begin
            queue_ticks(1);
          end
        end
      end
    end

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // sampled on the falling edge, clear of the driver and monitor updates
    while (cmd_q.size() != 0 || in_if.valid) @(negedge clk_i);
    while (tone_q.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);

    if (fail_cnt == 0 && tone_q.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
